/* src/mrr_pkg.sv */
`timescale 1ns / 1ps

package mrr_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int CLIENTS_DEF   = 8;
    localparam int WORD_BITS_DEF = 64;

    localparam logic [2:0] KIND_PUSH  = 3'd0;
    localparam logic [2:0] KIND_PEEK  = 3'd1;
    localparam logic [2:0] KIND_POP   = 3'd2;
    localparam logic [2:0] KIND_LEN   = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

endpackage

/* src/mrr_item_if.sv */
`timescale 1ns / 1ps

interface mrr_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] data_word;
    logic [31:0] position;
    logic [2:0]  client;

    modport source (output valid, output kind, output data_word, output position,
                    output client, input ready);
    modport sink   (input valid, input kind, input data_word, input position,
                    input client, output ready);
endinterface

/* src/mrr_result_if.sv */
`timescale 1ns / 1ps

interface mrr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] read_word;
    logic [10:0] unread_count;
    logic [31:0] total_written;

    modport source (output valid, output status, output read_word, output unread_count,
                    output total_written, input ready);
    modport sink   (input valid, input status, input read_word, input unread_count,
                    input total_written, output ready);
endinterface

/* src/multi_reader_overwrite_ring.sv */
`timescale 1ns / 1ps

// Ring of DEPTH words with one writer and up to CLIENTS readers, each with its own read
// position. The input transfer reads the reader-position memory. The execute state then
// writes or reads the ring memory, and the response state loads the result register. A new
// command is taken only once the last one has left the response state. The result sits in
// an output register, so the next command is taken while it waits. That next command then
// holds in the response state until the waiting result is transferred. The ring memory is
// never cleared. Reader positions carry valid bits that reset and clear drop at once, so
// no clearing pass is needed and the block is ready right after reset.
module multi_reader_overwrite_ring #(
    parameter int DEPTH     = mrr_pkg::DEPTH_DEF,
    parameter int CLIENTS   = mrr_pkg::CLIENTS_DEF,
    parameter int WORD_BITS = mrr_pkg::WORD_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    mrr_item_if.sink     item,
    mrr_result_if.source result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam logic [31:0]   DEPTH_W  = 32'(DEPTH);
    localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    mrr_pkg::state_t state_reg, state_next;

    logic                 accept;
    logic                 load;
    logic [CW+2:0]        client_ext;
    logic [CW-1:0]        cidx_in;
    logic                 client_ok_in;

    logic [2:0]           kind_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [31:0]          position_reg;
    logic [CW-1:0]        cidx_reg;
    logic                 client_ok_reg;

    logic [31:0]          count_reg, count_next;
    logic [31:0]          start_reg, start_next;
    logic [IW-1:0]        wr_idx_reg, wr_idx_next;
    logic [CLIENTS-1:0]   pos_valid_reg;

    logic [31:0]          pos_mem [CLIENTS];
    logic [31:0]          pos_rdata_reg;
    logic                 pos_rvalid_reg;
    logic [WORD_BITS-1:0] ent_mem [DEPTH];
    logic [WORD_BITS-1:0] ent_rdata_reg;

    logic [1:0]           status_reg, status_next;
    logic                 hit_reg, hit_next;
    logic [31:0]          pos_post_reg, pos_post_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg;
    logic [63:0]          out_word_reg;
    logic [10:0]          out_unread_reg;
    logic [31:0]          out_total_reg;

    logic [31:0]          pos_raw, pos_c, sel_pos, back;
    logic [IW:0]          diff, wrapped;
    logic [IW-1:0]        rd_idx;
    logic                 pos_we, pos_clear, ent_we, ent_re;
    logic [31:0]          pos_wdata;
    logic [31:0]          from_pos, live;

    assign accept       = item.valid && item.ready;
    assign load         = (state_reg == mrr_pkg::ST_RESP) && (!out_valid_reg || result.ready);
    assign client_ext   = {{CW{1'b0}}, item.client};
    assign cidx_in      = client_ext[CW-1:0];
    assign client_ok_in = client_ext < (CW + 3)'(CLIENTS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrr_pkg::ST_IDLE: if (accept) state_next = mrr_pkg::ST_EXEC;
            mrr_pkg::ST_EXEC: state_next = mrr_pkg::ST_RESP;
            mrr_pkg::ST_RESP: if (load) state_next = mrr_pkg::ST_IDLE;
            default:          state_next = mrr_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        item.ready = (state_reg == mrr_pkg::ST_IDLE);
    end

    // Ring index of an absolute position in the live window: step back from the write
    // index by the distance to the write count, wrapping once.
    always_comb
    begin
        pos_raw = pos_rvalid_reg ? pos_rdata_reg : 32'd0;
        pos_c   = (pos_raw < start_reg) ? start_reg : pos_raw;
        sel_pos = (kind_reg == mrr_pkg::KIND_PEEK) ? position_reg : pos_c;
        back    = count_reg - sel_pos;
        diff    = {1'b0, wr_idx_reg} - back[IW:0];
        wrapped = diff + DEPTH_X;
        rd_idx  = diff[IW] ? wrapped[IW-1:0] : diff[IW-1:0];
    end

    // Command execution.
    always_comb
    begin
        count_next    = count_reg;
        start_next    = start_reg;
        wr_idx_next   = wr_idx_reg;
        pos_we        = 1'b0;
        pos_clear     = 1'b0;
        pos_wdata     = pos_c;
        ent_we        = 1'b0;
        ent_re        = 1'b0;
        status_next   = status_reg;
        hit_next      = hit_reg;
        pos_post_next = pos_post_reg;
        if (state_reg == mrr_pkg::ST_EXEC)
        begin
            status_next   = mrr_pkg::STATUS_OK;
            hit_next      = 1'b0;
            pos_post_next = pos_raw;
            case (kind_reg)
                mrr_pkg::KIND_PUSH:
                begin
                    if (count_reg == mrr_pkg::COUNT_MAX)
                    begin
                        status_next = mrr_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ent_we      = 1'b1;
                        count_next  = count_reg + 32'd1;
                        wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
                        if (count_reg >= DEPTH_W)
                        begin
                            start_next = start_reg + 32'd1;
                        end
                    end
                end
                mrr_pkg::KIND_PEEK:
                begin
                    if (position_reg < count_reg && position_reg >= start_reg)
                    begin
                        ent_re   = 1'b1;
                        hit_next = 1'b1;
                    end
                    else
                    begin
                        status_next = mrr_pkg::STATUS_EMPTY;
                    end
                end
                mrr_pkg::KIND_POP:
                begin
                    if (!client_ok_reg)
                    begin
                        status_next = mrr_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        pos_we        = 1'b1;
                        pos_post_next = pos_c;
                        if (pos_c >= count_reg)
                        begin
                            status_next = mrr_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            ent_re        = 1'b1;
                            hit_next      = 1'b1;
                            pos_post_next = pos_c + 32'd1;
                        end
                        pos_wdata = pos_post_next;
                    end
                end
                mrr_pkg::KIND_LEN:
                begin
                    if (client_ok_reg)
                    begin
                        pos_we        = 1'b1;
                        pos_post_next = pos_c;
                    end
                    else
                    begin
                        status_next = mrr_pkg::STATUS_EMPTY;
                    end
                end
                mrr_pkg::KIND_CLEAR:
                begin
                    count_next    = 32'd0;
                    start_next    = 32'd0;
                    wr_idx_next   = '0;
                    pos_clear     = 1'b1;
                    pos_post_next = 32'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result: the state registers already hold the values after the command.
    always_comb
    begin
        from_pos       = (pos_post_reg > start_reg) ? pos_post_reg : start_reg;
        live           = (from_pos >= count_reg) ? 32'd0 : count_reg - from_pos;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrr_pkg::ST_IDLE;
            count_reg     <= 32'd0;
            start_reg     <= 32'd0;
            wr_idx_reg    <= '0;
            pos_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            wr_idx_reg    <= wr_idx_next;
            out_valid_reg <= out_valid_next;
            if (pos_clear)
            begin
                pos_valid_reg <= '0;
            end
            else if (pos_we)
            begin
                pos_valid_reg[cidx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= item.kind;
            word_reg      <= item.data_word[WORD_BITS-1:0];
            position_reg  <= item.position;
            cidx_reg      <= cidx_in;
            client_ok_reg <= client_ok_in;
        end
        status_reg   <= status_next;
        hit_reg      <= hit_next;
        pos_post_reg <= pos_post_next;
        if (load)
        begin
            out_status_reg <= status_reg;
            out_word_reg   <= hit_reg ? 64'(ent_rdata_reg) : 64'd0;
            out_unread_reg <= client_ok_reg ? live[10:0] : 11'd0;
            out_total_reg  <= count_reg;
        end
    end

    // Reader-position memory.
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[cidx_reg] <= pos_wdata;
        end
        if (accept)
        begin
            pos_rdata_reg  <= pos_mem[cidx_in];
            pos_rvalid_reg <= pos_valid_reg[cidx_in];
        end
    end

    // Ring memory.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[wr_idx_reg] <= word_reg;
        end
        if (ent_re)
        begin
            ent_rdata_reg <= ent_mem[rd_idx];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.read_word     = out_word_reg;
    assign result.unread_count  = out_unread_reg;
    assign result.total_written = out_total_reg;

    a_start_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= DEPTH_W) ? (start_reg == count_reg - DEPTH_W) : (start_reg == 32'd0))
        else $error("window start out of step with write count");

    a_wr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= LAST_IDX)
        else $error("write index beyond ring");

    a_read_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ent_re |-> rd_idx <= LAST_IDX)
        else $error("ring read index beyond ring");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrr_pkg::ST_EXEC && kind_reg == mrr_pkg::KIND_PUSH
         && count_reg != mrr_pkg::COUNT_MAX) |=> count_reg == $past(count_reg) + 32'd1)
        else $error("push did not advance the write count");

    a_no_input_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrr_pkg::ST_EXEC) |-> !item.ready)
        else $error("input taken while a command is in flight");

endmodule
